// File: sv/ctrdrbg_pkg.sv
package ctrdrbg_pkg;

  // Item modes
  localparam logic [2:0] MODE_LOAD_ENT  = 3'd0;
  localparam logic [2:0] MODE_LOAD_EXT  = 3'd1;
  localparam logic [2:0] MODE_INST      = 3'd2;
  localparam logic [2:0] MODE_RESEED    = 3'd3;
  localparam logic [2:0] MODE_GEN_START = 3'd4;
  localparam logic [2:0] MODE_GEN_BLOCK = 3'd5;
  localparam logic [2:0] MODE_UNINST    = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_RESEED_REQ = 2'd1;
  localparam logic [1:0] ST_TOO_LONG   = 2'd2;
  localparam logic [1:0] ST_NO_GEN     = 2'd3;

  // Update data selection
  localparam logic [1:0] SEL_ZERO  = 2'd0;
  localparam logic [1:0] SEL_SEED  = 2'd1;
  localparam logic [1:0] SEL_EXTRA = 2'd2;

  // Register address of the request limit between reseeds
  localparam logic [3:0] ADDR_REQ_LIMIT = 4'd0;

  localparam int unsigned NUM_WORDS   = 6;
  localparam int unsigned CNT_W       = 49;
  localparam int unsigned REQ_W       = 17;
  localparam logic [3:0]  NUM_ROUNDS  = 4'd14;
  localparam logic [16:0] MAX_REQUEST = 17'd65536;
  localparam logic [16:0] BLOCK_BYTES = 17'd16;
  localparam logic [1:0]  LAST_UPD_BLK = 2'd2;
  localparam logic [CNT_W-1:0] INTERVAL_RESET = 49'h1_0000_0000_0000;

  typedef struct packed {
    logic       capture;
    logic       clr_kv;
    logic       clr_gen;
    logic       clr_count;
    logic       set_count1;
    logic       finish;
    logic       gen_start;
    logic       enc_init;
    logic       enc_round;
    logic [3:0] round;
    logic       t_shift;
    logic       apply;
    logic [1:0] data_sel;
    logic       blk_take;
    logic       res_init;
    logic [1:0] res_status;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       use_extra;
    logic       too_long;
    logic       reseed_req;
    logic       gen_active;
    logic       rb_zero;
    logic       rem_le16;
    logic       fue;
  } stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [2:0] i);
    case (i)
      3'd0:    rcon = 8'h01;
      3'd1:    rcon = 8'h02;
      3'd2:    rcon = 8'h04;
      3'd3:    rcon = 8'h08;
      3'd4:    rcon = 8'h10;
      3'd5:    rcon = 8'h20;
      3'd6:    rcon = 8'h40;
      default: rcon = 8'h00;
    endcase
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One full AES round without the round key; byte 0 sits in the top bits.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] sb [16];
    logic [7:0] o  [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) sb[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) o[i+4*c] = sb[i + 4*((c+i) & 3)];
    for (int c = 0; c < 4; c++) begin
      a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                             a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
    end
    aes_round = r;
  endfunction

  // Next four key-schedule words from an eight-word window, for round key r+1.
  function automatic logic [127:0] key_step(input logic [255:0] w, input logic [3:0] r);
    logic [31:0] t, n0, n1, n2, n3;
    if (r[0]) begin
      t = sub_word({w[23:0], w[31:24]}) ^ {rcon(r[3:1]), 24'h0};
    end else begin
      t = sub_word(w[31:0]);
    end
    n0 = w[255:224] ^ t;
    n1 = w[223:192] ^ n0;
    n2 = w[191:160] ^ n1;
    n3 = w[159:128] ^ n2;
    key_step = {n0, n1, n2, n3};
  endfunction

endpackage

// File: sv/aes256_ctr_drbg_core.sv
// Loads, checks and commands that need no cipher work pass from the accepting edge through
// dispatch to the result; a generate block adds one AES-256 encryption, and every DRBG
// update adds three counter blocks and one step to apply the new key and V.
// The iterative AES-256 round unit computes one round per cycle.
// One transaction at a time: the next input can be taken in the same cycle as the result
// appears, with no wait for out_ready. Synchronous reset clears
// key, V, counters and the flags, and sets the request limit to 2^48.
module aes256_ctr_drbg_core (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [2:0]  word_index,
  input  logic [63:0] data_word,
  input  logic        use_extra,
  input  logic [16:0] request_bytes,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] random_high,
  output logic [63:0] random_low,
  output logic [4:0]  valid_bytes,
  output logic        last_block,
  output logic [1:0]  status,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ctrdrbg_pkg::*;

  ctrdrbg_pkg::cmd_t  cmd;
  ctrdrbg_pkg::stat_t st;
  logic               cfg_we;
  logic [48:0]        req_limit;

  // The single register is written in the access phase of an APB write transaction.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && paddr == ADDR_REQ_LIMIT;
  assign prdata = (paddr == ADDR_REQ_LIMIT) ? {15'h0, req_limit} : 64'h0;

  // The controller sequences commands and cipher rounds; the datapath holds the DRBG state and buffers.
  ctrdrbg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ctrdrbg_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .mode            (mode),
    .word_index      (word_index),
    .data_word       (data_word),
    .use_extra       (use_extra),
    .request_bytes   (request_bytes),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata[48:0]),
    .req_limit       (req_limit),
    .random_high     (random_high),
    .random_low      (random_low),
    .valid_bytes     (valid_bytes),
    .last_block      (last_block),
    .status          (status)
  );

endmodule

// File: sv/ctrdrbg_dp.sv
module ctrdrbg_dp (
  input  logic                clk,
  input  logic                rst,
  input  ctrdrbg_pkg::cmd_t   cmd,
  output ctrdrbg_pkg::stat_t  st,
  input  logic [2:0]          mode,
  input  logic [2:0]          word_index,
  input  logic [63:0]         data_word,
  input  logic                use_extra,
  input  logic [16:0]         request_bytes,
  input  logic                cfg_we,
  input  logic [48:0]         cfg_wdata,
  output logic [48:0]         req_limit,
  output logic [63:0]         random_high,
  output logic [63:0]         random_low,
  output logic [4:0]          valid_bytes,
  output logic                last_block,
  output logic [1:0]          status
);
  import ctrdrbg_pkg::*;

  logic [2:0]       mode_q;
  logic             ue_q;
  logic [16:0]      rb_q;
  logic [255:0]     drbg_key;
  logic [127:0]     counter_block;
  logic [CNT_W-1:0] request_count;
  logic [63:0]      entropy_buffer [NUM_WORDS];
  logic [63:0]      extra_buffer   [NUM_WORDS];
  logic [255:0]     key_win;
  logic [127:0]     aes_state;
  logic [383:0]     t_buf;
  logic [16:0]      bytes_remaining;
  logic             generate_active;
  logic             final_uses_extra;
  logic [63:0]      res_hi, res_lo;
  logic [4:0]       res_valid;
  logic             res_last;
  logic [1:0]       res_status;

  logic [383:0] ent_flat, ext_flat, upd_data, upd_res;
  logic [127:0] v_inc, round_out;
  logic [4:0]   blk_n;

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      ent_flat[383-64*i -: 64] = entropy_buffer[i];
      ext_flat[383-64*i -: 64] = extra_buffer[i];
    end
    case (cmd.data_sel)
      SEL_SEED:  upd_data = ent_flat ^ (ue_q ? ext_flat : 384'h0);
      SEL_EXTRA: upd_data = ext_flat;
      default:   upd_data = 384'h0;
    endcase
  end

  assign upd_res   = t_buf ^ upd_data;
  assign v_inc     = counter_block + 128'd1;
  assign round_out = aes_round(aes_state, cmd.round == NUM_ROUNDS) ^ key_win[127:0];
  assign blk_n     = st.rem_le16 ? bytes_remaining[4:0] : 5'd16;

  assign st.mode       = mode_q;
  assign st.use_extra  = ue_q;
  assign st.too_long   = rb_q > MAX_REQUEST;
  assign st.reseed_req = request_count > req_limit;
  assign st.gen_active = generate_active;
  assign st.rb_zero    = rb_q == 17'd0;
  assign st.rem_le16   = bytes_remaining <= BLOCK_BYTES;
  assign st.fue        = final_uses_extra;

  // Item capture and buffers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      ue_q   <= use_extra;
      rb_q   <= request_bytes;
      if (word_index < 3'(NUM_WORDS)) begin
        if (mode == MODE_LOAD_ENT) entropy_buffer[word_index] <= data_word;
        if (mode == MODE_LOAD_EXT) extra_buffer[word_index] <= data_word;
      end
    end
  end

  // AES working registers
  always_ff @(posedge clk) begin
    if (cmd.enc_init) begin
      aes_state <= v_inc ^ drbg_key[255:128];
      key_win   <= drbg_key;
    end else if (cmd.enc_round) begin
      aes_state <= round_out;
      key_win   <= {key_win[127:0], key_step(key_win, cmd.round)};
    end
    if (cmd.t_shift) t_buf <= {t_buf[255:0], aes_state};
  end

  // DRBG state
  always_ff @(posedge clk) begin
    if (rst) begin
      drbg_key         <= '0;
      counter_block    <= '0;
      request_count    <= '0;
      bytes_remaining  <= '0;
      generate_active  <= 1'b0;
      final_uses_extra <= 1'b0;
      req_limit        <= INTERVAL_RESET;
    end else begin
      if (cfg_we) req_limit <= cfg_wdata;
      if (cmd.clr_kv) begin
        drbg_key      <= '0;
        counter_block <= '0;
      end else if (cmd.apply) begin
        drbg_key      <= upd_res[383:128];
        counter_block <= upd_res[127:0];
      end else if (cmd.enc_init) begin
        counter_block <= v_inc;
      end
      if (cmd.clr_count) request_count <= '0;
      else if (cmd.set_count1) request_count <= CNT_W'(1);
      else if (cmd.finish && request_count != {CNT_W{1'b1}})
        request_count <= request_count + CNT_W'(1);
      if (cmd.clr_gen || cmd.finish) begin
        generate_active <= 1'b0;
        bytes_remaining <= '0;
      end else if (cmd.gen_start) begin
        generate_active  <= rb_q != 17'd0;
        bytes_remaining  <= rb_q;
        final_uses_extra <= ue_q;
      end else if (cmd.blk_take) begin
        bytes_remaining <= bytes_remaining - 17'(blk_n);
      end
    end
  end

  // Working result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_init) begin
      res_hi     <= '0;
      res_lo     <= '0;
      res_valid  <= '0;
      res_last   <= 1'b0;
      res_status <= cmd.res_status;
    end else if (cmd.blk_take) begin
      res_hi    <= aes_state[127:64];
      res_lo    <= aes_state[63:0];
      res_valid <= blk_n;
      res_last  <= st.rem_le16;
    end
    if (cmd.out_load) begin
      random_high <= res_hi;
      random_low  <= res_lo;
      valid_bytes <= res_valid;
      last_block  <= res_last;
      status      <= res_status;
    end
  end

endmodule

// File: sv/ctrdrbg_ctrl.sv
module ctrdrbg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ctrdrbg_pkg::stat_t st,
  output ctrdrbg_pkg::cmd_t  cmd
);
  import ctrdrbg_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_ENC_INIT = 3'd2;
  localparam logic [2:0] S_ENC_RND  = 3'd3;
  localparam logic [2:0] S_ENC_DONE = 3'd4;
  localparam logic [2:0] S_APPLY    = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  localparam logic [1:0] RET_SET1   = 2'd0;
  localparam logic [1:0] RET_GSTART = 2'd1;
  localparam logic [1:0] RET_FINISH = 2'd2;

  logic [2:0] state, state_next;
  logic [3:0] round, round_next;
  logic [1:0] blk_cnt, blk_cnt_next;
  logic       is_block, is_block_next;
  logic [1:0] ret, ret_next;
  logic [1:0] sel, sel_next;
  logic       out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.capture   = in_valid && in_ready;
    cmd.round     = round;
    cmd.data_sel  = sel;
    state_next    = state;
    round_next    = round;
    blk_cnt_next  = blk_cnt;
    is_block_next = is_block;
    ret_next      = ret;
    sel_next      = sel;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd.res_init   = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_RESP;
        is_block_next  = 1'b0;
        blk_cnt_next   = 2'd0;
        case (st.mode)
          MODE_INST: begin
            cmd.clr_kv  = 1'b1;
            cmd.clr_gen = 1'b1;
            sel_next    = SEL_SEED;
            ret_next    = RET_SET1;
            state_next  = S_ENC_INIT;
          end
          MODE_RESEED: begin
            cmd.clr_gen = 1'b1;
            sel_next    = SEL_SEED;
            ret_next    = RET_SET1;
            state_next  = S_ENC_INIT;
          end
          MODE_GEN_START: begin
            if (st.too_long) begin
              cmd.res_status = ST_TOO_LONG;
            end else if (st.reseed_req) begin
              cmd.res_status = ST_RESEED_REQ;
            end else begin
              cmd.gen_start = 1'b1;
              if (st.use_extra) begin
                sel_next   = SEL_EXTRA;
                ret_next   = RET_GSTART;
                state_next = S_ENC_INIT;
              end else if (st.rb_zero) begin
                sel_next   = SEL_ZERO;
                ret_next   = RET_FINISH;
                state_next = S_ENC_INIT;
              end
            end
          end
          MODE_GEN_BLOCK: begin
            if (!st.gen_active) begin
              cmd.res_status = ST_NO_GEN;
            end else begin
              is_block_next = 1'b1;
              state_next    = S_ENC_INIT;
            end
          end
          MODE_UNINST: begin
            cmd.clr_kv    = 1'b1;
            cmd.clr_gen   = 1'b1;
            cmd.clr_count = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_ENC_INIT: begin
        cmd.enc_init = 1'b1;
        round_next   = 4'd1;
        state_next   = S_ENC_RND;
      end
      S_ENC_RND: begin
        cmd.enc_round = 1'b1;
        round_next    = round + 4'd1;
        if (round == NUM_ROUNDS) state_next = S_ENC_DONE;
      end
      S_ENC_DONE: begin
        if (is_block) begin
          cmd.blk_take = 1'b1;
          state_next   = S_RESP;
          if (st.rem_le16) begin
            is_block_next = 1'b0;
            blk_cnt_next  = 2'd0;
            sel_next      = st.fue ? SEL_EXTRA : SEL_ZERO;
            ret_next      = RET_FINISH;
            state_next    = S_ENC_INIT;
          end
        end else begin
          cmd.t_shift = 1'b1;
          if (blk_cnt == LAST_UPD_BLK) begin
            state_next = S_APPLY;
          end else begin
            blk_cnt_next = blk_cnt + 2'd1;
            state_next   = S_ENC_INIT;
          end
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_RESP;
        case (ret)
          RET_SET1: cmd.set_count1 = 1'b1;
          RET_GSTART: begin
            if (st.rb_zero) begin
              blk_cnt_next = 2'd0;
              sel_next     = st.fue ? SEL_EXTRA : SEL_ZERO;
              ret_next     = RET_FINISH;
              state_next   = S_ENC_INIT;
            end
          end
          default: cmd.finish = 1'b1;
        endcase
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      round     <= '0;
      blk_cnt   <= '0;
      is_block  <= 1'b0;
      ret       <= RET_SET1;
      sel       <= SEL_ZERO;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      round    <= round_next;
      blk_cnt  <= blk_cnt_next;
      is_block <= is_block_next;
      ret      <= ret_next;
      sel      <= sel_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DISPATCH)
    else $error("accepted transaction not dispatched");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENC_RND && round == NUM_ROUNDS) |=> state == S_ENC_DONE)
    else $error("cipher did not stop after the last round");

  a_resp_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not presented");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready while busy");

endmodule
